>>> rtl/brf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// brf_pkg
// Shared types, mode codes and bank decode functions for the banked
// register file.
// -----------------------------------------------------------------------------
package brf_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned MODE_W  = 5;

  localparam int unsigned LOW_DEPTH = 8;
  localparam int unsigned FIQ_DEPTH = 10;
  localparam int unsigned SL_DEPTH  = 12;
  localparam int unsigned SPSR_DEPTH = 5;
  localparam int unsigned SL_BANKS  = 6;

  localparam int unsigned LOW_AW  = $clog2(LOW_DEPTH);
  localparam int unsigned FIQ_AW  = $clog2(FIQ_DEPTH);
  localparam int unsigned SL_AW   = $clog2(SL_DEPTH);
  localparam int unsigned SPSR_AW = $clog2(SPSR_DEPTH);

  localparam logic [MODE_W-1:0] MODE_USR = 5'h10;
  localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
  localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
  localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
  localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
  localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;
  localparam logic [MODE_W-1:0] MODE_SYS = 5'h1F;

  localparam logic [IDX_W-1:0] PC_INDEX = 4'd15;
  localparam logic [IDX_W-1:0] SP_INDEX = 4'd13;
  localparam logic [IDX_W-1:0] LR_INDEX = 4'd14;
  localparam logic [IDX_W-1:0] BANKED_HIGH = 4'd12;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  typedef enum logic [OP_W-1:0] {
    OP_READ_REG   = 3'd0,
    OP_WRITE_REG  = 3'd1,
    OP_READ_CPSR  = 3'd2,
    OP_WRITE_CPSR = 3'd3,
    OP_READ_SPSR  = 3'd4,
    OP_WRITE_SPSR = 3'd5,
    OP_STATUS     = 3'd6
  } brf_op_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [IDX_W-1:0]  reg_index;
    logic [MODE_W-1:0] mode_select;
    logic [DATA_W-1:0] write_value;
  } brf_item_t;

  // bank lookup result: hit flag plus slot
  typedef struct packed {
    logic             hit;
    logic [SL_AW-1:0] slot;
  } brf_sl_sel_t;

  typedef struct packed {
    logic               hit;
    logic [SPSR_AW-1:0] slot;
  } brf_spsr_sel_t;

  // r13/r14 bank; USR and SYS share bank 0
  function automatic brf_sl_sel_t sl_bank(input logic [MODE_W-1:0] m);
    brf_sl_sel_t s;
    s.hit  = 1'b1;
    s.slot = '0;
    unique case (m)
      MODE_USR, MODE_SYS: s.slot = SL_AW'(0);
      MODE_FIQ:           s.slot = SL_AW'(1);
      MODE_IRQ:           s.slot = SL_AW'(2);
      MODE_SVC:           s.slot = SL_AW'(3);
      MODE_UND:           s.slot = SL_AW'(4);
      MODE_ABT:           s.slot = SL_AW'(5);
      default:            s.hit  = 1'b0;
    endcase
    return s;
  endfunction

  function automatic brf_spsr_sel_t spsr_slot(input logic [MODE_W-1:0] m);
    brf_spsr_sel_t s;
    s.hit  = 1'b1;
    s.slot = '0;
    unique case (m)
      MODE_FIQ: s.slot = SPSR_AW'(0);
      MODE_IRQ: s.slot = SPSR_AW'(1);
      MODE_SVC: s.slot = SPSR_AW'(2);
      MODE_ABT: s.slot = SPSR_AW'(3);
      MODE_UND: s.slot = SPSR_AW'(4);
      default:  s.hit  = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic mode_defined(input logic [MODE_W-1:0] m);
    brf_spsr_sel_t s;
    s = spsr_slot(m);
    return (m == MODE_USR) || (m == MODE_SYS) || s.hit;
  endfunction

endpackage
`default_nettype wire

>>> rtl/brf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// brf_in_if / brf_out_if
// Valid/ready channels for access words and result words.
// -----------------------------------------------------------------------------
interface brf_in_if
  import brf_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  reg_index;
  logic [MODE_W-1:0] mode_select;
  logic [DATA_W-1:0] write_value;

  modport source (output valid, output operation, output reg_index,
                  output mode_select, output write_value, input ready);
  modport sink   (input valid, input operation, input reg_index,
                  input mode_select, input write_value, output ready);
endinterface

interface brf_out_if
  import brf_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [MODE_W-1:0] active_mode;
  logic              active_mode_valid;
  logic              is_privileged;
  logic              has_saved_status;

  modport source (output valid, output read_data, output active_mode,
                  output active_mode_valid, output is_privileged,
                  output has_saved_status, input ready);
  modport sink   (input valid, input read_data, input active_mode,
                  input active_mode_valid, input is_privileged,
                  input has_saved_status, output ready);
endinterface
`default_nettype wire

>>> rtl/brf_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// brf_in_stage
// Input register: captures one access word per cycle when it is empty or downstream moves.
// -----------------------------------------------------------------------------
module brf_in_stage
  import brf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire brf_item_t in_item,
  output logic           acc_valid,
  input  wire logic      acc_ready,
  output brf_item_t      acc_item
);

  logic      valid_r;
  brf_item_t item_r;

  assign in_ready  = !valid_r || acc_ready;
  assign acc_valid = valid_r;
  assign acc_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/brf_core.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// brf_core
// Register storage, CPSR/SPSR, mode decode and the result register.
// -----------------------------------------------------------------------------
module brf_core
  import brf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      acc_valid,
  output logic           acc_ready,
  input  wire brf_item_t acc_item,
  brf_out_if.source      out_ch
);

  logic [DATA_W-1:0] pc_r;
  logic [DATA_W-1:0] low_r  [LOW_DEPTH];
  logic [DATA_W-1:0] fiq_r  [FIQ_DEPTH];
  logic [DATA_W-1:0] sl_r   [SL_DEPTH];
  logic [DATA_W-1:0] spsr_r [SPSR_DEPTH];
  logic [DATA_W-1:0] cpsr_r;
  logic [MODE_W-1:0] mode_r;
  logic              mode_ok_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] rdata_r;
  logic [MODE_W-1:0] omode_r;
  logic              omode_ok_r;
  logic              opriv_r;
  logic              ospsr_r;

  logic              fire;
  brf_op_t           op;
  logic [IDX_W-1:0]  r;
  logic [MODE_W-1:0] m;
  brf_sl_sel_t       sl_sel;
  brf_spsr_sel_t     sp_sel;
  brf_spsr_sel_t     nxt_sel;
  logic [FIQ_AW-1:0] fiq_idx;
  logic [SL_AW-1:0]  sl_idx;
  logic              is_pc, is_low, is_fiq, is_sl;
  logic [DATA_W-1:0] reg_rd;
  logic [DATA_W-1:0] rdata_nxt;
  logic              wr_reg, wr_cpsr, wr_spsr;
  logic [MODE_W-1:0] mode_nxt;
  logic              mode_ok_nxt;

  assign acc_ready = !out_valid_r || out_ch.ready;
  assign fire      = acc_valid && acc_ready;

  assign op = brf_op_t'(acc_item.operation);
  assign r  = acc_item.reg_index;
  assign m  = acc_item.mode_select;

  assign sl_sel = sl_bank(m);
  assign sp_sel = spsr_slot(m);

  assign is_pc  = (r == PC_INDEX);
  assign is_low = !r[IDX_W-1];
  assign is_fiq = r[IDX_W-1] && (r <= BANKED_HIGH);
  assign is_sl  = ((r == SP_INDEX) || (r == LR_INDEX)) && sl_sel.hit;

  // r8..r12: low bits give r-8, FIQ copy sits on the odd entry
  assign fiq_idx = {r[FIQ_AW-2:0], (m == MODE_FIQ)};
  assign sl_idx  = (r == LR_INDEX) ? (SL_AW'(SL_BANKS) + sl_sel.slot) : sl_sel.slot;

  always_comb begin
    if (is_pc) begin
      reg_rd = pc_r;
    end else if (is_low) begin
      reg_rd = low_r[r[LOW_AW-1:0]];
    end else if (is_fiq) begin
      reg_rd = fiq_r[fiq_idx];
    end else if (is_sl) begin
      reg_rd = sl_r[sl_idx];
    end else begin
      reg_rd = ALL_ONES;
    end
  end

  always_comb begin
    rdata_nxt = '0;
    wr_reg    = 1'b0;
    wr_cpsr   = 1'b0;
    wr_spsr   = 1'b0;
    unique case (op)
      OP_READ_REG:   rdata_nxt = reg_rd;
      OP_WRITE_REG:  wr_reg    = fire;
      OP_READ_CPSR:  rdata_nxt = cpsr_r;
      OP_WRITE_CPSR: wr_cpsr   = fire;
      OP_READ_SPSR:  rdata_nxt = sp_sel.hit ? spsr_r[sp_sel.slot] : ALL_ONES;
      OP_WRITE_SPSR: wr_spsr   = fire && sp_sel.hit;
      default:       rdata_nxt = '0;
    endcase
  end

  // result reports the mode after this access
  assign mode_nxt    = wr_cpsr ? acc_item.write_value[MODE_W-1:0] : mode_r;
  assign mode_ok_nxt = wr_cpsr ? mode_defined(acc_item.write_value[MODE_W-1:0])
                               : mode_ok_r;
  assign nxt_sel     = spsr_slot(mode_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      cpsr_r    <= '0;
      mode_r    <= MODE_SVC;
      mode_ok_r <= 1'b1;
      for (int i = 0; i < LOW_DEPTH; i++) low_r[i] <= '0;
      for (int i = 0; i < FIQ_DEPTH; i++) fiq_r[i] <= '0;
      for (int i = 0; i < SL_DEPTH; i++) sl_r[i] <= '0;
      for (int i = 0; i < SPSR_DEPTH; i++) spsr_r[i] <= '0;
    end else begin
      if (wr_reg) begin
        if (is_pc) begin
          pc_r <= acc_item.write_value;
        end else if (is_low) begin
          low_r[r[LOW_AW-1:0]] <= acc_item.write_value;
        end else if (is_fiq) begin
          fiq_r[fiq_idx] <= acc_item.write_value;
        end else if (is_sl) begin
          sl_r[sl_idx] <= acc_item.write_value;
        end
      end
      if (wr_cpsr) begin
        cpsr_r <= acc_item.write_value;
      end
      if (wr_spsr) begin
        spsr_r[sp_sel.slot] <= acc_item.write_value;
      end
      mode_r    <= mode_nxt;
      mode_ok_r <= mode_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_ready) begin
      out_valid_r <= acc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rdata_r    <= rdata_nxt;
      omode_r    <= mode_nxt;
      omode_ok_r <= mode_ok_nxt;
      opriv_r    <= !(mode_ok_nxt && ((mode_nxt == MODE_USR) || (mode_nxt == MODE_SYS)));
      ospsr_r    <= mode_ok_nxt && nxt_sel.hit;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.read_data         = rdata_r;
  assign out_ch.active_mode       = omode_r;
  assign out_ch.active_mode_valid = omode_ok_r;
  assign out_ch.is_privileged     = opriv_r;
  assign out_ch.has_saved_status  = ospsr_r;

endmodule
`default_nettype wire

>>> rtl/banked_register_file.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// banked_register_file
// Mode-banked register file with CPSR and five SPSRs, one access per word.
// -----------------------------------------------------------------------------
//  Channel | Dir | Handshake    | Payload
//  in_ch   | in  | valid/ready  | operation, reg_index, mode_select, write_value
//  out_ch  | out | valid/ready  | read_data, active_mode, active_mode_valid,
//          |     |              | is_privileged, has_saved_status
//
//  One word per cycle sustained while out_ch is ready; each word passes the input
//  register, then the access and result register. State updates when a word
//  moves into the result register, so accesses take effect in order.
//  rst_n (synchronous) clears storage, CPSR, SPSRs and valid bits; mode is SVC.
//  A stalled out_ch holds its word; in_ch keeps accepting until the input
//  register is also full.
// -----------------------------------------------------------------------------
module banked_register_file
  import brf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  brf_in_if.sink    in_ch,
  brf_out_if.source out_ch
);

  brf_item_t in_item;
  brf_item_t acc_item;
  logic      acc_valid;
  logic      acc_ready;

  assign in_item.operation   = in_ch.operation;
  assign in_item.reg_index   = in_ch.reg_index;
  assign in_item.mode_select = in_ch.mode_select;
  assign in_item.write_value = in_ch.write_value;

  brf_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .acc_valid (acc_valid),
    .acc_ready (acc_ready),
    .acc_item  (acc_item)
  );

  brf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_valid (acc_valid),
    .acc_ready (acc_ready),
    .acc_item  (acc_item),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
